// File: hdl/sppt_pkg.sv
// shared types and codes for the strong probable prime test block
`timescale 1ns / 1ps
`default_nettype none

package sppt_pkg;

    // verdict codes on the result port
    typedef enum logic [1:0] {
        VERDICT_PRIME     = 2'd0,
        VERDICT_COMPOSITE = 2'd1,
        VERDICT_FERMAT    = 2'd2,
        VERDICT_INVALID   = 2'd3
    } t_verdict;

    // operation selects for the shared modular multiplier
    typedef enum logic [1:0] {
        MUL_REDUCE = 2'd0,   // z = a mod n, done as 1 * a mod n
        MUL_Y_Z    = 2'd1,   // y = y * z mod n
        MUL_SQ_Z   = 2'd2,   // z = z * z mod n, then d >>= 1
        MUL_SQ_Y   = 2'd3    // prev = y, y = y * y mod n, s -= 1
    } t_mul_op;

    // controller to datapath
    typedef struct packed {
        logic    load;
        logic    shift_factor;
        logic    mul_start;
        t_mul_op mul_op;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic invalid;
        logic d_even;
        logic d_zero;
        logic d_bit;
        logic y_one;
        logic prev_nm1;
        logic s_zero;
        logic mul_done;
    } t_dp_status;

endpackage

`default_nettype wire

// File: hdl/sppt_modmul.sv
// bit-serial double-and-add modular multiplier, one bit of the multiplier per cycle
`timescale 1ns / 1ps
`default_nettype none

module sppt_modmul #(
    parameter int NUM_WIDTH = 64
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_start,
    input  wire logic [NUM_WIDTH-1:0] i_x,
    input  wire logic [NUM_WIDTH-1:0] i_y,
    input  wire logic [NUM_WIDTH-1:0] i_n,
    output logic                      o_done,
    output logic [NUM_WIDTH-1:0]      o_result
);

    localparam int CW = $clog2(NUM_WIDTH);

    logic                 r_busy;
    logic                 r_done;
    logic [NUM_WIDTH-1:0] r_acc;
    logic [NUM_WIDTH-1:0] n_acc;
    logic [NUM_WIDTH-1:0] r_y;
    logic [CW-1:0]        r_cnt;

    logic [NUM_WIDTH:0]   w_dbl;
    logic [NUM_WIDTH:0]   w_sum;
    logic [NUM_WIDTH:0]   w_n_ext;
    logic [NUM_WIDTH-1:0] w_t1;
    logic [NUM_WIDTH-1:0] w_t2;

    // acc < n and x < n keep both sums below 2n
    assign w_n_ext = {1'b0, i_n};
    assign w_dbl   = {r_acc, 1'b0};
    assign w_t1    = (w_dbl >= w_n_ext) ? NUM_WIDTH'(w_dbl - w_n_ext) : w_dbl[NUM_WIDTH-1:0];
    assign w_sum   = {1'b0, w_t1} + {1'b0, i_x};
    assign w_t2    = (w_sum >= w_n_ext) ? NUM_WIDTH'(w_sum - w_n_ext) : w_sum[NUM_WIDTH-1:0];
    assign n_acc   = r_y[NUM_WIDTH-1] ? w_t2 : w_t1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start && !r_busy) begin
                r_busy <= 1'b1;
            end else if (r_busy && (r_cnt == '0)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start && !r_busy) begin
            r_acc <= '0;
            r_y   <= i_y;
            r_cnt <= CW'(NUM_WIDTH - 1);
        end else if (r_busy) begin
            r_acc <= n_acc;
            r_y   <= {r_y[NUM_WIDTH-2:0], 1'b0};
            r_cnt <= r_cnt - 1'b1;
        end
    end

    assign o_done   = r_done;
    assign o_result = r_acc;

`ifndef SYNTH
    a_done_after_busy : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_busy))
        else $error("multiplier done without a running product");

    a_acc_reduced : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_acc < i_n))
        else $error("partial product not reduced below the modulus");
`endif

endmodule

`default_nettype wire

// File: hdl/sppt_datapath.sv
// operand registers, factoring of n-1 and the shared modular multiplier
`timescale 1ns / 1ps
`default_nettype none

module sppt_datapath #(
    parameter int NUM_WIDTH = 64
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire sppt_pkg::t_dp_cmd    i_cmd,
    input  wire logic [63:0]          i_modulus,
    input  wire logic [63:0]          i_witness_base,
    output sppt_pkg::t_dp_status      o_status
);

    localparam int SW = $clog2(NUM_WIDTH);

    logic [NUM_WIDTH-1:0] r_n;
    logic [NUM_WIDTH-1:0] r_a;
    logic [NUM_WIDTH-1:0] r_z;
    logic [NUM_WIDTH-1:0] r_y;
    logic [NUM_WIDTH-1:0] r_d;
    logic [NUM_WIDTH-1:0] r_prev;
    logic [SW-1:0]        r_s;
    sppt_pkg::t_mul_op    r_op;

    logic [NUM_WIDTH-1:0] w_mul_x;
    logic [NUM_WIDTH-1:0] w_mul_y;
    logic [NUM_WIDTH-1:0] w_mul_res;
    logic                 w_mul_done;

    // x is read through the whole product, so it follows the latched op
    always_comb begin
        unique case (r_op)
            sppt_pkg::MUL_REDUCE: w_mul_x = NUM_WIDTH'(1);
            sppt_pkg::MUL_Y_Z:    w_mul_x = r_y;
            sppt_pkg::MUL_SQ_Z:   w_mul_x = r_z;
            sppt_pkg::MUL_SQ_Y:   w_mul_x = r_y;
        endcase
    end

    // y is captured by the multiplier at start
    always_comb begin
        unique case (i_cmd.mul_op)
            sppt_pkg::MUL_REDUCE: w_mul_y = r_a;
            sppt_pkg::MUL_Y_Z:    w_mul_y = r_z;
            sppt_pkg::MUL_SQ_Z:   w_mul_y = r_z;
            sppt_pkg::MUL_SQ_Y:   w_mul_y = r_y;
        endcase
    end

    sppt_modmul #(
        .NUM_WIDTH (NUM_WIDTH)
    ) u_modmul (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (i_cmd.mul_start),
        .i_x      (w_mul_x),
        .i_y      (w_mul_y),
        .i_n      (r_n),
        .o_done   (w_mul_done),
        .o_result (w_mul_res)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_n <= i_modulus[NUM_WIDTH-1:0];
            r_a <= i_witness_base[NUM_WIDTH-1:0];
            r_d <= i_modulus[NUM_WIDTH-1:0] - 1'b1;
            r_s <= '0;
            r_y <= NUM_WIDTH'(1);
        end else if (i_cmd.shift_factor) begin
            r_d <= r_d >> 1;
            r_s <= r_s + 1'b1;
        end else if (w_mul_done) begin
            unique case (r_op)
                sppt_pkg::MUL_REDUCE: r_z <= w_mul_res;
                sppt_pkg::MUL_Y_Z:    r_y <= w_mul_res;
                sppt_pkg::MUL_SQ_Z: begin
                    r_z <= w_mul_res;
                    r_d <= r_d >> 1;
                end
                sppt_pkg::MUL_SQ_Y: begin
                    r_prev <= r_y;
                    r_y    <= w_mul_res;
                    r_s    <= r_s - 1'b1;
                end
            endcase
        end
    end

    // latched op, kept defined from reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_op <= sppt_pkg::MUL_REDUCE;
        end else if (i_cmd.mul_start) begin
            r_op <= i_cmd.mul_op;
        end
    end

    assign o_status.invalid  = (r_n < NUM_WIDTH'(3)) || !r_n[0];
    assign o_status.d_even   = !r_d[0];
    assign o_status.d_zero   = (r_d == '0);
    assign o_status.d_bit    = r_d[0];
    assign o_status.y_one    = (r_y == NUM_WIDTH'(1));
    assign o_status.prev_nm1 = (r_prev == (r_n - 1'b1));
    assign o_status.s_zero   = (r_s == '0);
    assign o_status.mul_done = w_mul_done;

endmodule

`default_nettype wire

// File: hdl/sppt_ctrl.sv
// sequencing state machine and result register
`timescale 1ns / 1ps
`default_nettype none

module sppt_ctrl (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 start,
    output logic                      busy,
    input  wire sppt_pkg::t_dp_status i_status,
    output sppt_pkg::t_dp_cmd         o_cmd,
    output logic [1:0]                o_verdict,
    output logic                      o_verdict_valid
);

    typedef enum logic [9:0] {
        S_IDLE     = 10'b0000000001,
        S_CHECK    = 10'b0000000010,
        S_FACTOR   = 10'b0000000100,
        S_W_REDUCE = 10'b0000001000,
        S_EXP      = 10'b0000010000,
        S_W_MUL_YZ = 10'b0000100000,
        S_W_SQ_Z   = 10'b0001000000,
        S_Y_TEST   = 10'b0010000000,
        S_W_SQ_Y   = 10'b0100000000,
        S_SQ_TEST  = 10'b1000000000
    } t_state;

    t_state             r_state;
    t_state             n_state;
    logic               r_valid;
    logic               n_valid;
    sppt_pkg::t_verdict r_verdict;
    sppt_pkg::t_verdict n_verdict;

    always_comb begin
        n_state   = r_state;
        n_valid   = 1'b0;
        n_verdict = r_verdict;
        o_cmd     = '0;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_CHECK;
                end
            end
            S_CHECK: begin
                if (i_status.invalid) begin
                    n_valid   = 1'b1;
                    n_verdict = sppt_pkg::VERDICT_INVALID;
                    n_state   = S_IDLE;
                end else begin
                    n_state = S_FACTOR;
                end
            end
            S_FACTOR: begin
                if (i_status.d_even) begin
                    o_cmd.shift_factor = 1'b1;
                end else begin
                    o_cmd.mul_start = 1'b1;
                    o_cmd.mul_op    = sppt_pkg::MUL_REDUCE;
                    n_state         = S_W_REDUCE;
                end
            end
            S_W_REDUCE: begin
                if (i_status.mul_done) begin
                    n_state = S_EXP;
                end
            end
            S_EXP: begin
                if (i_status.d_zero) begin
                    n_state = S_Y_TEST;
                end else if (i_status.d_bit) begin
                    o_cmd.mul_start = 1'b1;
                    o_cmd.mul_op    = sppt_pkg::MUL_Y_Z;
                    n_state         = S_W_MUL_YZ;
                end else begin
                    o_cmd.mul_start = 1'b1;
                    o_cmd.mul_op    = sppt_pkg::MUL_SQ_Z;
                    n_state         = S_W_SQ_Z;
                end
            end
            S_W_MUL_YZ: begin
                if (i_status.mul_done) begin
                    o_cmd.mul_start = 1'b1;
                    o_cmd.mul_op    = sppt_pkg::MUL_SQ_Z;
                    n_state         = S_W_SQ_Z;
                end
            end
            S_W_SQ_Z: begin
                if (i_status.mul_done) begin
                    n_state = S_EXP;
                end
            end
            S_Y_TEST: begin
                if (i_status.y_one) begin
                    n_valid   = 1'b1;
                    n_verdict = sppt_pkg::VERDICT_PRIME;
                    n_state   = S_IDLE;
                end else if (i_status.s_zero) begin
                    n_valid   = 1'b1;
                    n_verdict = sppt_pkg::VERDICT_COMPOSITE;
                    n_state   = S_IDLE;
                end else begin
                    o_cmd.mul_start = 1'b1;
                    o_cmd.mul_op    = sppt_pkg::MUL_SQ_Y;
                    n_state         = S_W_SQ_Y;
                end
            end
            S_W_SQ_Y: begin
                if (i_status.mul_done) begin
                    n_state = S_SQ_TEST;
                end
            end
            S_SQ_TEST: begin
                if (i_status.y_one) begin
                    n_valid   = 1'b1;
                    n_verdict = i_status.prev_nm1 ? sppt_pkg::VERDICT_PRIME
                                                  : sppt_pkg::VERDICT_FERMAT;
                    n_state   = S_IDLE;
                end else if (i_status.s_zero) begin
                    n_valid   = 1'b1;
                    n_verdict = sppt_pkg::VERDICT_COMPOSITE;
                    n_state   = S_IDLE;
                end else begin
                    o_cmd.mul_start = 1'b1;
                    o_cmd.mul_op    = sppt_pkg::MUL_SQ_Y;
                    n_state         = S_W_SQ_Y;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_verdict <= n_verdict;
    end

    assign busy            = (r_state != S_IDLE);
    assign o_verdict       = r_verdict;
    assign o_verdict_valid = r_valid;

`ifndef SYNTH
    a_valid_in_idle : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> (r_state == S_IDLE))
        else $error("verdict strobe while a test is still running");

    a_single_strobe : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |=> !r_valid)
        else $error("verdict strobe held for more than one cycle");
`endif

endmodule

`default_nettype wire

// File: hdl/strong_probable_prime_test.sv
// top level of the single-base strong probable prime test
// the test factors n-1 into d * 2^s, reduces the base mod n, runs the exponent ladder over the
// bits of d from the low end, then squares y until it reaches 1 or s runs out; an even modulus or
// one below 3 ends the test at the check with the invalid verdict
// throughput: one test at a time, next beat once busy falls; set by the bit-serial multiplier
// reset: synchronous, active low, drops any test in progress; the verdict strobe cannot stall
`timescale 1ns / 1ps
`default_nettype none

module strong_probable_prime_test #(
    parameter int NUM_WIDTH = 64
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [63:0] i_modulus,
    input  wire logic [63:0] i_witness_base,
    output logic [1:0]       o_verdict,
    output logic             o_verdict_valid
);

    // command and status between the sequencer and the datapath
    sppt_pkg::t_dp_cmd    w_cmd;
    sppt_pkg::t_dp_status w_status;

    // sequencer: factoring n-1, reduction of the base, the exponent ladder,
    // then the squaring run, and the verdict register
    sppt_ctrl u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_status        (w_status),
        .o_cmd           (w_cmd),
        .o_verdict       (o_verdict),
        .o_verdict_valid (o_verdict_valid)
    );

    // datapath: n, base, d, y, z and the previous y, plus the multiplier;
    // only the low NUM_WIDTH bits of each input beat are taken
    sppt_datapath #(
        .NUM_WIDTH (NUM_WIDTH)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .i_modulus      (i_modulus),
        .i_witness_base (i_witness_base),
        .o_status       (w_status)
    );

endmodule

`default_nettype wire
